// File: hw/rtl/btpa_pkg.sv
package btpa_pkg;

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_REALLOC = 3'd2;
  localparam logic [2:0] OP_RESET   = 3'd3;
  localparam logic [2:0] OP_USED    = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_BADPTR  = 3'd2;
  localparam logic [2:0] ST_DBLFREE = 3'd3;
  localparam logic [2:0] ST_CORRUPT = 3'd4;
  localparam logic [2:0] ST_ZERO    = 3'd5;

  typedef enum logic [5:0] {
    C_NOP, C_LATCH, C_CLR, C_RI0, C_RI1, C_RI2,
    C_ALLOC_INIT, C_LIST_INIT, C_RD_CUR, C_RD_CURHDR, C_ADV, C_UNLINK,
    C_RD_HDR_CUR, C_BLK, C_BLK_USER,
    C_WR_HDR_RQ, C_WR_FTR_RQ, C_WR_REST_H, C_WR_REST_F, C_PUSH_REST,
    C_WR_HDR_BLK1, C_WR_FTR_BLK1, C_NP_CUR, C_SET_ADDR_NP, C_SET_ADDR_P,
    C_RD_HDR_P, C_WR_HDR_BLK, C_WR_FTR_BLK,
    C_RD_PREVFTR, C_PREV_TG, C_MERGE_PREV,
    C_RD_NXT, C_NXT_TG, C_MERGE_NXT, C_PUSH_HDR,
    C_COPY_INIT, C_RD_COPY, C_WR_COPY,
    C_SCAN_INIT, C_RD_POS, C_SCAN_STEP,
    C_ST_NOFIT, C_ST_BADPTR, C_ST_DBLFREE, C_ST_CORRUPT, C_ST_ZERO
  } dp_cmd_t;

  typedef struct packed {
    logic size_zero;
    logic p_zero;
    logic p_valid;
    logic cur_zero;
    logic cur_bad;
    logic cur_is_tg;
    logic fit;
    logic split_ok;
    logic h_alloc;
    logic f_bad;
    logic hdr_gt4;
    logic tag_free;
    logic nxt_in;
    logic grow_ok;
    logic in_place;
    logic st_zero;
    logic copy_done;
    logic scan_end;
    logic scan_stop;
    logic clr_last;
  } dp_stat_t;

  typedef enum logic [5:0] {
    S_IDLE, S_DISP, S_DONE,
    S_CLR, S_RI0, S_RI1, S_RI2,
    S_A0, S_FF0, S_FF1, S_FF2, S_FFBRK,
    S_AS0, S_AS1, S_AS2, S_AS3, S_AS4, S_AS5, S_AS6, S_AN2, S_AFIN, S_ARET,
    S_UL1, S_RM0, S_RM1, S_RM2,
    S_F0, S_FERR, S_F1, S_F2, S_F2B, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8,
    S_F9, S_F10, S_F11,
    S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7, S_RMA, S_CP0, S_CP1, S_RFD,
    S_SC0, S_SC1
  } ctl_state_t;

endpackage

// File: hw/rtl/btpa_datapath.sv
module btpa_datapath import btpa_pkg::*; #(
  parameter int unsigned POOL_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [15:0] req_bytes,
  input  logic [15:0] block_addr,
  output dp_stat_t    stat,
  output logic [15:0] result_addr,
  output logic [2:0]  status,
  output logic [16:0] used_bytes
);

  localparam int unsigned NW   = POOL_BYTES / 4;
  localparam int unsigned WIDX = $clog2(NW);
  localparam int unsigned CW   = $clog2(NW + 2);
  localparam logic [31:0] PB   = 32'(POOL_BYTES);
  localparam logic [31:0] NWL  = 32'(NW);
  localparam logic [31:0] MINB = 32'd12;

  function automatic logic valid_pl(input logic [31:0] p);
    valid_pl = (p[1:0] == 2'b00) && (p >= 32'd4) && (p <= PB - 32'd4);
  endfunction

  logic [31:0] mem [NW];
  logic [31:0] q_r;
  logic        rd_ok_r;
  logic        mem_we, mem_re;
  logic [31:0] mem_a, mem_wd;

  logic [15:0]     pp_r, pp_nxt, size_r, size_nxt, addr_r, addr_nxt;
  logic [31:0]     hdr_r, hdr_nxt, blk_r, blk_nxt, rq_r, rq_nxt, cur_r, cur_nxt;
  logic [31:0]     prev_r, prev_nxt, nh_r, nh_nxt, tg_r, tg_nxt, np_r, np_nxt;
  logic [31:0]     user_r, user_nxt, fh_r, fh_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [WIDX-1:0] clr_r, clr_nxt;
  logic [15:0]     ci_r, ci_nxt, words_r, words_nxt;
  logic [33:0]     pos_r, pos_nxt;
  logic [16:0]     used_r, used_nxt;
  logic [2:0]      st_r, st_nxt;

  logic [31:0] rdata, rmask, s3, need, rq_calc, nx, pq, nmin;
  logic [31:0] size32, ci4;
  logic [17:0] wsum;
  logic [32:0] usum;

  assign rdata   = rd_ok_r ? q_r : 32'd0;
  assign rmask   = {rdata[31:1], 1'b0};
  assign size32  = {16'd0, size_r};
  assign s3      = size32 + 32'd3;
  assign need    = {s3[31:2], 2'b00} + 32'd8;
  assign rq_calc = (need < MINB) ? MINB : need;
  assign nx      = (rdata != 32'd0 && !valid_pl(rdata)) ? 32'd0 : rdata;
  assign nmin    = (user_r < size32) ? user_r : size32;
  assign wsum    = nmin[17:0] + 18'd3;
  assign ci4     = {14'd0, ci_r, 2'b00};
  assign usum    = {16'd0, used_r} + {1'b0, rmask};

  always_comb begin
    stat.size_zero = (size_r == 16'd0);
    stat.p_zero    = (pp_r == 16'd0);
    stat.p_valid   = valid_pl({16'd0, pp_r});
    stat.cur_zero  = (cur_r == 32'd0);
    stat.cur_bad   = !valid_pl(cur_r) || (cnt_r > CW'(NW));
    stat.cur_is_tg = (cur_r == tg_r);
    stat.fit       = (rmask >= rq_r);
    stat.split_ok  = ((blk_r - rq_r) >= MINB);
    stat.h_alloc   = rdata[0];
    stat.f_bad     = (rmask < MINB) || (rmask > PB) || ((hdr_r + rmask) > PB);
    stat.hdr_gt4   = (hdr_r > 32'd4);
    stat.tag_free  = !rdata[0];
    stat.nxt_in    = ((hdr_r + blk_r) < (PB - 32'd4));
    stat.grow_ok   = !rdata[0] && ((blk_r + rmask) >= need);
    stat.in_place  = (size32 <= user_r);
    stat.st_zero   = (st_r == ST_OK);
    stat.copy_done = (ci_r >= words_r);
    stat.scan_end  = ((pos_r + 34'd4) > {2'b00, PB});
    stat.scan_stop = (rdata == 32'd0) || (rmask == 32'd0);
    stat.clr_last  = (clr_r == WIDX'(NW - 1));
  end

  always_comb begin
    mem_we = 1'b0; mem_re = 1'b0; mem_a = 32'd0; mem_wd = 32'd0;
    pp_nxt = pp_r; size_nxt = size_r; addr_nxt = addr_r; hdr_nxt = hdr_r;
    blk_nxt = blk_r; rq_nxt = rq_r; cur_nxt = cur_r; prev_nxt = prev_r;
    nh_nxt = nh_r; tg_nxt = tg_r; np_nxt = np_r; user_nxt = user_r;
    fh_nxt = fh_r; cnt_nxt = cnt_r; clr_nxt = clr_r; ci_nxt = ci_r;
    words_nxt = words_r; pos_nxt = pos_r; used_nxt = used_r; st_nxt = st_r;
    pq = 32'd0;
    unique case (cmd)
      C_NOP: ;
      C_LATCH: begin
        size_nxt = req_bytes; pp_nxt = block_addr;
        st_nxt = ST_OK; addr_nxt = 16'd0; used_nxt = 17'd0; np_nxt = 32'd0;
      end
      C_CLR: begin
        mem_we = 1'b1; mem_a = {{(30 - WIDX){1'b0}}, clr_r, 2'b00}; mem_wd = 32'd0;
        clr_nxt = stat.clr_last ? '0 : clr_r + 1'b1;
      end
      C_RI0: begin mem_we = 1'b1; mem_a = 32'd0; mem_wd = PB; end
      C_RI1: begin mem_we = 1'b1; mem_a = PB - 32'd4; mem_wd = PB; end
      C_RI2: begin mem_we = 1'b1; mem_a = 32'd4; mem_wd = 32'd0; fh_nxt = 32'd4; end
      C_ALLOC_INIT: begin
        rq_nxt = rq_calc; np_nxt = 32'd0;
        prev_nxt = 32'd0; cur_nxt = fh_r; cnt_nxt = '0;
      end
      C_LIST_INIT: begin prev_nxt = 32'd0; cur_nxt = fh_r; cnt_nxt = '0; end
      C_RD_CUR: begin mem_re = 1'b1; mem_a = cur_r; end
      C_RD_CURHDR: begin mem_re = 1'b1; mem_a = cur_r - 32'd4; end
      C_ADV: begin prev_nxt = cur_r; cur_nxt = rdata; cnt_nxt = cnt_r + 1'b1; end
      C_UNLINK: begin
        if (prev_r != 32'd0) begin
          mem_we = 1'b1; mem_a = prev_r; mem_wd = nx;
        end else begin
          fh_nxt = nx;
        end
      end
      C_RD_HDR_CUR: begin
        hdr_nxt = cur_r - 32'd4; mem_re = 1'b1; mem_a = cur_r - 32'd4;
      end
      C_BLK: blk_nxt = rmask;
      C_BLK_USER: begin blk_nxt = rmask; user_nxt = rmask - 32'd8; end
      C_WR_HDR_RQ: begin mem_we = 1'b1; mem_a = hdr_r; mem_wd = rq_r | 32'd1; end
      C_WR_FTR_RQ: begin
        mem_we = 1'b1; mem_a = hdr_r + rq_r - 32'd4; mem_wd = rq_r | 32'd1;
      end
      C_WR_REST_H: begin mem_we = 1'b1; mem_a = hdr_r + rq_r; mem_wd = blk_r - rq_r; end
      C_WR_REST_F: begin
        mem_we = 1'b1; mem_a = hdr_r + blk_r - 32'd4; mem_wd = blk_r - rq_r;
      end
      C_PUSH_REST, C_PUSH_HDR: begin
        pq = (cmd == C_PUSH_REST) ? hdr_r + rq_r + 32'd4 : hdr_r + 32'd4;
        if (valid_pl(pq)) begin
          mem_we = 1'b1; mem_a = pq; mem_wd = fh_r; fh_nxt = pq;
        end
      end
      C_WR_HDR_BLK1: begin mem_we = 1'b1; mem_a = hdr_r; mem_wd = blk_r | 32'd1; end
      C_WR_FTR_BLK1: begin
        mem_we = 1'b1; mem_a = hdr_r + blk_r - 32'd4; mem_wd = blk_r | 32'd1;
      end
      C_NP_CUR: np_nxt = cur_r;
      C_SET_ADDR_NP: addr_nxt = np_r[15:0];
      C_SET_ADDR_P: addr_nxt = pp_r;
      C_RD_HDR_P: begin
        hdr_nxt = {16'd0, pp_r} - 32'd4; mem_re = 1'b1; mem_a = {16'd0, pp_r} - 32'd4;
      end
      C_WR_HDR_BLK: begin mem_we = 1'b1; mem_a = hdr_r; mem_wd = blk_r & ~32'd1; end
      C_WR_FTR_BLK: begin
        mem_we = 1'b1; mem_a = hdr_r + blk_r - 32'd4; mem_wd = blk_r & ~32'd1;
      end
      C_RD_PREVFTR: begin mem_re = 1'b1; mem_a = hdr_r - 32'd4; end
      C_PREV_TG: begin nh_nxt = rmask; tg_nxt = hdr_r - rmask + 32'd4; end
      C_MERGE_PREV: begin hdr_nxt = hdr_r - nh_r; blk_nxt = blk_r + nh_r; end
      C_RD_NXT: begin mem_re = 1'b1; mem_a = hdr_r + blk_r; end
      C_NXT_TG: begin nh_nxt = rmask; tg_nxt = hdr_r + blk_r + 32'd4; end
      C_MERGE_NXT: blk_nxt = blk_r + nh_r;
      C_COPY_INIT: begin ci_nxt = 16'd0; words_nxt = wsum[17:2]; end
      C_RD_COPY: begin mem_re = 1'b1; mem_a = {16'd0, pp_r} + ci4; end
      C_WR_COPY: begin
        mem_we = 1'b1; mem_a = np_r + ci4; mem_wd = rdata; ci_nxt = ci_r + 16'd1;
      end
      C_SCAN_INIT: begin pos_nxt = 34'd0; used_nxt = 17'd0; end
      C_RD_POS: begin mem_re = 1'b1; mem_a = pos_r[31:0]; end
      C_SCAN_STEP: begin
        if (rdata[0]) used_nxt = (usum > 33'h1FFFF) ? 17'h1FFFF : usum[16:0];
        pos_nxt = pos_r + {2'b00, rmask};
      end
      C_ST_NOFIT:   st_nxt = ST_NOFIT;
      C_ST_BADPTR:  st_nxt = ST_BADPTR;
      C_ST_DBLFREE: st_nxt = ST_DBLFREE;
      C_ST_CORRUPT: st_nxt = ST_CORRUPT;
      C_ST_ZERO:    st_nxt = ST_ZERO;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we && ((mem_a >> 2) < NWL)) mem[mem_a[WIDX+1:2]] <= mem_wd;
    if (mem_re) begin
      rd_ok_r <= ((mem_a >> 2) < NWL);
      q_r     <= mem[mem_a[WIDX+1:2]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pp_r <= pp_nxt; size_r <= size_nxt; addr_r <= addr_nxt; hdr_r <= hdr_nxt;
    blk_r <= blk_nxt; rq_r <= rq_nxt; cur_r <= cur_nxt; prev_r <= prev_nxt;
    nh_r <= nh_nxt; tg_r <= tg_nxt; np_r <= np_nxt; user_r <= user_nxt;
    fh_r <= fh_nxt; cnt_r <= cnt_nxt; ci_r <= ci_nxt; words_r <= words_nxt;
    pos_r <= pos_nxt; used_r <= used_nxt; st_r <= st_nxt;
  end

  assign result_addr = addr_r;
  assign status      = st_r;
  assign used_bytes  = used_r;

endmodule

// File: hw/rtl/btpa_ctrl.sv
module btpa_ctrl import btpa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] opcode,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       out_valid
);

  ctl_state_t state_r, state_nxt;
  ctl_state_t ret_ri_r, ret_ri_nxt, ret_ul_r, ret_ul_nxt;
  ctl_state_t ret_rm_r, ret_rm_nxt, ret_al_r, ret_al_nxt, ret_fr_r, ret_fr_nxt;
  logic [2:0] op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      ret_ri_r <= S_IDLE;
      ret_ul_r <= S_IDLE;
      ret_rm_r <= S_IDLE;
      ret_al_r <= S_IDLE;
      ret_fr_r <= S_IDLE;
      op_r     <= OP_ALLOC;
    end else begin
      state_r  <= state_nxt;
      ret_ri_r <= ret_ri_nxt;
      ret_ul_r <= ret_ul_nxt;
      ret_rm_r <= ret_rm_nxt;
      ret_al_r <= ret_al_nxt;
      ret_fr_r <= ret_fr_nxt;
      op_r     <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_ri_nxt = ret_ri_r; ret_ul_nxt = ret_ul_r; ret_rm_nxt = ret_rm_r;
    ret_al_nxt = ret_al_r; ret_fr_nxt = ret_fr_r; op_nxt = op_r;
    cmd = C_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd = C_LATCH; op_nxt = opcode; state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (op_r)
          OP_ALLOC:   begin ret_al_nxt = S_ARET; state_nxt = S_A0; end
          OP_FREE:    begin ret_fr_nxt = S_DONE; state_nxt = S_F0; end
          OP_REALLOC: state_nxt = S_R0;
          OP_RESET:   begin ret_ri_nxt = S_DONE; state_nxt = S_CLR; end
          OP_USED:    begin cmd = C_SCAN_INIT; state_nxt = S_SC0; end
          default:    state_nxt = S_DONE;
        endcase
      end
      S_DONE: state_nxt = S_IDLE;
      S_CLR: begin
        cmd = C_CLR;
        if (stat.clr_last) state_nxt = S_RI0;
      end
      S_RI0: begin cmd = C_RI0; state_nxt = S_RI1; end
      S_RI1: begin cmd = C_RI1; state_nxt = S_RI2; end
      S_RI2: begin cmd = C_RI2; state_nxt = ret_ri_r; end
      S_A0: begin
        if (stat.size_zero) begin
          cmd = C_ST_ZERO; state_nxt = ret_al_r;
        end else begin
          cmd = C_ALLOC_INIT; state_nxt = S_FF0;
        end
      end
      S_FF0: begin
        if (stat.cur_zero) begin
          cmd = C_ST_NOFIT; state_nxt = ret_al_r;
        end else if (stat.cur_bad) begin
          ret_ri_nxt = S_FFBRK; state_nxt = S_RI0;
        end else begin
          cmd = C_RD_CURHDR; state_nxt = S_FF1;
        end
      end
      S_FF1: begin
        cmd = C_RD_CUR;
        if (stat.fit) begin
          ret_ul_nxt = S_AS0; state_nxt = S_UL1;
        end else begin
          state_nxt = S_FF2;
        end
      end
      S_FF2: begin cmd = C_ADV; state_nxt = S_FF0; end
      S_FFBRK: begin cmd = C_ST_CORRUPT; state_nxt = ret_al_r; end
      S_AS0: begin cmd = C_RD_HDR_CUR; state_nxt = S_AS1; end
      S_AS1: begin cmd = C_BLK; state_nxt = S_AS2; end
      S_AS2: begin
        if (stat.split_ok) begin
          cmd = C_WR_HDR_RQ; state_nxt = S_AS3;
        end else begin
          cmd = C_WR_HDR_BLK1; state_nxt = S_AN2;
        end
      end
      S_AS3: begin cmd = C_WR_FTR_RQ; state_nxt = S_AS4; end
      S_AS4: begin cmd = C_WR_REST_H; state_nxt = S_AS5; end
      S_AS5: begin cmd = C_WR_REST_F; state_nxt = S_AS6; end
      S_AS6: begin cmd = C_PUSH_REST; state_nxt = S_AFIN; end
      S_AN2: begin cmd = C_WR_FTR_BLK1; state_nxt = S_AFIN; end
      S_AFIN: begin cmd = C_NP_CUR; state_nxt = ret_al_r; end
      S_ARET: begin cmd = C_SET_ADDR_NP; state_nxt = S_DONE; end
      S_UL1: begin cmd = C_UNLINK; state_nxt = ret_ul_r; end
      S_RM0: begin cmd = C_LIST_INIT; state_nxt = S_RM1; end
      S_RM1: begin
        if (stat.cur_zero) begin
          state_nxt = ret_rm_r;
        end else if (stat.cur_bad) begin
          ret_ri_nxt = ret_rm_r; state_nxt = S_RI0;
        end else if (stat.cur_is_tg) begin
          cmd = C_RD_CUR; ret_ul_nxt = ret_rm_r; state_nxt = S_UL1;
        end else begin
          cmd = C_RD_CUR; state_nxt = S_RM2;
        end
      end
      S_RM2: begin cmd = C_ADV; state_nxt = S_RM1; end
      S_F0: begin
        if (stat.p_zero) begin
          state_nxt = ret_fr_r;
        end else if (!stat.p_valid) begin
          cmd = C_ST_BADPTR; state_nxt = S_FERR;
        end else begin
          cmd = C_RD_HDR_P; state_nxt = S_F1;
        end
      end
      S_FERR: begin ret_ri_nxt = ret_fr_r; state_nxt = S_CLR; end
      S_F1: begin
        if (!stat.h_alloc) begin
          cmd = C_ST_DBLFREE; state_nxt = S_FERR;
        end else if (stat.f_bad) begin
          cmd = C_ST_CORRUPT; state_nxt = S_FERR;
        end else begin
          cmd = C_BLK; state_nxt = S_F2;
        end
      end
      S_F2:  begin cmd = C_WR_HDR_BLK; state_nxt = S_F2B; end
      S_F2B: begin cmd = C_WR_FTR_BLK; state_nxt = S_F3; end
      S_F3: begin
        if (stat.hdr_gt4) begin
          cmd = C_RD_PREVFTR; state_nxt = S_F4;
        end else begin
          state_nxt = S_F6;
        end
      end
      S_F4: begin
        if (stat.tag_free) begin
          cmd = C_PREV_TG; ret_rm_nxt = S_F5; state_nxt = S_RM0;
        end else begin
          state_nxt = S_F6;
        end
      end
      S_F5: begin cmd = C_MERGE_PREV; state_nxt = S_F6; end
      S_F6: begin
        if (stat.nxt_in) begin
          cmd = C_RD_NXT; state_nxt = S_F7;
        end else begin
          state_nxt = S_F9;
        end
      end
      S_F7: begin
        if (stat.tag_free) begin
          cmd = C_NXT_TG; ret_rm_nxt = S_F8; state_nxt = S_RM0;
        end else begin
          state_nxt = S_F9;
        end
      end
      S_F8:  begin cmd = C_MERGE_NXT; state_nxt = S_F9; end
      S_F9:  begin cmd = C_WR_HDR_BLK; state_nxt = S_F10; end
      S_F10: begin cmd = C_WR_FTR_BLK; state_nxt = S_F11; end
      S_F11: begin cmd = C_PUSH_HDR; state_nxt = ret_fr_r; end
      S_R0: begin
        if (stat.p_zero) begin
          ret_al_nxt = S_ARET; state_nxt = S_A0;
        end else if (stat.size_zero) begin
          ret_fr_nxt = S_DONE; state_nxt = S_F0;
        end else if (!stat.p_valid) begin
          cmd = C_ST_BADPTR; ret_ri_nxt = S_DONE; state_nxt = S_CLR;
        end else begin
          cmd = C_RD_HDR_P; state_nxt = S_R1;
        end
      end
      S_R1: begin cmd = C_BLK_USER; state_nxt = S_R2; end
      S_R2: begin
        if (stat.in_place) begin
          cmd = C_SET_ADDR_P; state_nxt = S_DONE;
        end else if (stat.nxt_in) begin
          cmd = C_RD_NXT; state_nxt = S_R3;
        end else begin
          ret_al_nxt = S_RMA; state_nxt = S_A0;
        end
      end
      S_R3: begin
        if (stat.grow_ok) begin
          cmd = C_NXT_TG; ret_rm_nxt = S_R4; state_nxt = S_RM0;
        end else begin
          ret_al_nxt = S_RMA; state_nxt = S_A0;
        end
      end
      S_R4: begin cmd = C_MERGE_NXT; state_nxt = S_R5; end
      S_R5: begin cmd = C_WR_HDR_BLK1; state_nxt = S_R6; end
      S_R6: begin cmd = C_WR_FTR_BLK1; state_nxt = S_R7; end
      S_R7: begin cmd = C_SET_ADDR_P; state_nxt = S_DONE; end
      S_RMA: begin
        if (!stat.st_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd = C_COPY_INIT; state_nxt = S_CP0;
        end
      end
      S_CP0: begin
        if (stat.copy_done) begin
          ret_fr_nxt = S_RFD; state_nxt = S_F0;
        end else begin
          cmd = C_RD_COPY; state_nxt = S_CP1;
        end
      end
      S_CP1: begin cmd = C_WR_COPY; state_nxt = S_CP0; end
      S_RFD: begin
        if (stat.st_zero) cmd = C_SET_ADDR_NP;
        state_nxt = S_DONE;
      end
      S_SC0: begin
        if (stat.scan_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd = C_RD_POS; state_nxt = S_SC1;
        end
      end
      S_SC1: begin
        if (stat.scan_stop) begin
          state_nxt = S_DONE;
        end else begin
          cmd = C_SCAN_STEP; state_nxt = S_SC0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// File: hw/rtl/boundary_tag_pool_allocator_unit.sv
// Boundary-tag pool allocator: one command at a time on start/busy, one result
// per command on out_valid, which the receiver must take in that cycle. All
// tags and free-list links live in a single-port pool memory of POOL_BYTES/4
// words, and each step makes at most one access to it. Allocate walks the free
// list entry by entry, free may walk it up to twice to merge with free
// neighbours, reallocate may copy the old block word by word, and the
// used-bytes query steps block by block. Reset and the bad-pointer, double-free
// and corrupt-tag errors of free and reallocate clear the pool. After rst_n the
// pool is cleared, with busy high, before the first command is taken.
module boundary_tag_pool_allocator_unit import btpa_pkg::*; #(
  parameter int unsigned POOL_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_req_bytes,
  input  logic [15:0] in_block_addr,
  output logic        out_valid,
  output logic [15:0] out_result_addr,
  output logic [2:0]  out_status,
  output logic [16:0] out_used_bytes
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  btpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .opcode    (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  btpa_datapath #(.POOL_BYTES(POOL_BYTES)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .req_bytes   (in_req_bytes),
    .block_addr  (in_block_addr),
    .stat        (stat),
    .result_addr (out_result_addr),
    .status      (out_status),
    .used_bytes  (out_used_bytes)
  );

endmodule

// File: hw/rtl/btpa_checker.sv
module btpa_checker import btpa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [15:0] out_result_addr,
  input logic [2:0]  out_status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result not a single pulse ending the item");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside an item");

  a_err_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_addr == 16'd0)
    else $error("failed item returned an address");

endmodule

bind boundary_tag_pool_allocator_unit btpa_checker u_btpa_checker (.*);

// File: dv/boundary_tag_pool_allocator_unit_test.sv
`timescale 1ns / 100ps

module boundary_tag_pool_allocator_unit_test;
  import btpa_pkg::*;

  localparam int unsigned POOL_BYTES = 65536;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [15:0] addr;
    logic [2:0]  status;
    logic [16:0] used;
  } alloc_result_t;

  class alloc_scoreboard;
    localparam int unsigned NW = POOL_BYTES / 4;
    localparam int unsigned PB = POOL_BYTES;
    int unsigned   mem[NW];
    int unsigned   head;
    alloc_result_t pending[$];
    int            mismatches;

    function int unsigned rd(int unsigned a);
      return (a >> 2) < NW ? mem[a >> 2] : 0;
    endfunction

    function void wr(int unsigned a, int unsigned v);
      if ((a >> 2) < NW) mem[a >> 2] = v;
    endfunction

    function bit ok_ptr(int unsigned p);
      return (p & 3) == 0 && p >= 4 && p <= PB - 4;
    endfunction

    function void retag();
      wr(0, PB);
      wr(PB - 4, PB);
      head = 4;
      wr(4, 0);
    endfunction

    function void clear_pool();
      foreach (mem[i]) mem[i] = 0;
      retag();
    endfunction

    function void push_free(int unsigned p);
      if (!ok_ptr(p)) return;
      wr(p, head);
      head = p;
    endfunction

    function void unlink(int unsigned prev, int unsigned cur);
      int unsigned nxt;
      nxt = rd(cur);
      if (nxt != 0 && !ok_ptr(nxt)) nxt = 0;
      if (prev != 0) wr(prev, nxt);
      else head = nxt;
    endfunction

    function void drop_free(int unsigned target);
      int unsigned prev, cur, n;
      prev = 0; cur = head; n = 0;
      while (cur != 0) begin
        if (!ok_ptr(cur) || n > NW) begin
          retag();
          return;
        end
        if (cur == target) begin
          unlink(prev, cur);
          return;
        end
        prev = cur;
        cur = rd(cur);
        n++;
      end
    endfunction

    function int unsigned first_fit(int unsigned req, output bit broken);
      int unsigned prev, cur, n;
      prev = 0; cur = head; n = 0; broken = 0;
      while (cur != 0) begin
        if (!ok_ptr(cur) || n > NW) begin
          retag();
          broken = 1;
          return 0;
        end
        if ((rd(cur - 4) & ~32'd1) >= req) begin
          unlink(prev, cur);
          return cur;
        end
        prev = cur;
        cur = rd(cur);
        n++;
      end
      return 0;
    endfunction

    function logic [2:0] alloc_blk(int unsigned size, output int unsigned addr);
      int unsigned req, p, hdr, blk, rest;
      bit broken;
      addr = 0;
      if (size == 0) return ST_ZERO;
      req = ((size + 3) & ~32'd3) + 8;
      if (req < 12) req = 12;
      p = first_fit(req, broken);
      if (broken) return ST_CORRUPT;
      if (p == 0) return ST_NOFIT;
      hdr = p - 4;
      blk = rd(hdr) & ~32'd1;
      rest = blk - req;
      if (rest >= 12) begin
        wr(hdr, req | 1);
        wr(hdr + req - 4, req | 1);
        wr(hdr + req, rest);
        wr(hdr + req + rest - 4, rest);
        push_free(hdr + req + 4);
      end else begin
        wr(hdr, blk | 1);
        wr(hdr + blk - 4, blk | 1);
      end
      addr = p;
      return ST_OK;
    endfunction

    function logic [2:0] free_blk(int unsigned p);
      int unsigned hdr, h, blk, nxt, nh, pf, psz;
      if (p == 0) return ST_OK;
      if (!ok_ptr(p)) begin
        clear_pool();
        return ST_BADPTR;
      end
      hdr = p - 4;
      h = rd(hdr);
      blk = h & ~32'd1;
      if ((h & 1) == 0) begin
        clear_pool();
        return ST_DBLFREE;
      end
      if (blk < 12 || blk > PB || hdr + blk > PB) begin
        clear_pool();
        return ST_CORRUPT;
      end
      wr(hdr, blk);
      wr(hdr + blk - 4, blk);
      if (hdr > 4) begin
        pf = rd(hdr - 4);
        if ((pf & 1) == 0) begin
          psz = pf & ~32'd1;
          drop_free(hdr - psz + 4);
          hdr -= psz;
          blk += psz;
        end
      end
      nxt = hdr + blk;
      if (nxt < PB - 4) begin
        nh = rd(nxt);
        if ((nh & 1) == 0) begin
          drop_free(nxt + 4);
          blk += nh & ~32'd1;
        end
      end
      wr(hdr, blk & ~32'd1);
      wr(hdr + blk - 4, blk & ~32'd1);
      push_free(hdr + 4);
      return ST_OK;
    endfunction

    function logic [2:0] realloc_blk(int unsigned p, int unsigned size,
                                     output int unsigned addr);
      int unsigned hdr, blk, user, nxt, nh, comb, need, np, n;
      logic [2:0] st;
      addr = 0;
      if (p == 0) return alloc_blk(size, addr);
      if (size == 0) return free_blk(p);
      if (!ok_ptr(p)) begin
        clear_pool();
        return ST_BADPTR;
      end
      hdr = p - 4;
      blk = rd(hdr) & ~32'd1;
      user = blk - 8;
      if (size <= user) begin
        addr = p;
        return ST_OK;
      end
      nxt = hdr + blk;
      if (nxt < PB - 4) begin
        nh = rd(nxt);
        if ((nh & 1) == 0) begin
          comb = blk + (nh & ~32'd1);
          need = ((size + 3) & ~32'd3) + 8;
          if (comb >= need) begin
            drop_free(nxt + 4);
            wr(hdr, comb | 1);
            wr(hdr + comb - 4, comb | 1);
            addr = p;
            return ST_OK;
          end
        end
      end
      st = alloc_blk(size, np);
      if (st != ST_OK) return st;
      n = user < size ? user : size;
      for (int unsigned i = 0; i < (n + 3) / 4; i++) wr(np + 4 * i, rd(p + 4 * i));
      st = free_blk(p);
      if (st != ST_OK) return st;
      addr = np;
      return ST_OK;
    endfunction

    function logic [16:0] scan_used();
      longint unsigned pos, used;
      int unsigned h, sz;
      pos = 0; used = 0;
      while (pos + 4 <= PB) begin
        h = rd(int'(pos));
        sz = h & ~32'd1;
        if (h == 0 || sz == 0) break;
        if (h & 1) used += sz;
        pos += sz;
      end
      return used > 'h1FFFF ? 17'h1FFFF : used[16:0];
    endfunction

    function alloc_result_t note(logic [2:0] op, logic [15:0] req, logic [15:0] ba);
      alloc_result_t r;
      int unsigned a;
      a = 0;
      r.status = ST_OK;
      r.used = '0;
      case (op)
        OP_ALLOC:   r.status = alloc_blk(req, a);
        OP_FREE:    r.status = free_blk(ba);
        OP_REALLOC: r.status = realloc_blk(ba, req, a);
        OP_RESET:   clear_pool();
        OP_USED:    r.used = scan_used();
        default: ;
      endcase
      r.addr = a[15:0];
      pending.push_back(r);
      return r;
    endfunction

    function void check(logic [15:0] addr, logic [2:0] st, logic [16:0] used);
      alloc_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: addr %h status %0d used %0d",
                                       addr, st, used);
        return;
      end
      e = pending.pop_front();
      if (addr !== e.addr || st !== e.status || used !== e.used) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp addr %h status %0d used %0d, got addr %h status %0d used %0d",
                   e.addr, e.status, e.used, addr, st, used);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_opcode = '0;
  logic [15:0] in_req_bytes = '0;
  logic [15:0] in_block_addr = '0;
  logic        out_valid;
  logic [15:0] out_result_addr;
  logic [2:0]  out_status;
  logic [16:0] out_used_bytes;

  alloc_scoreboard sb = new();
  logic [15:0]     live[$];
  longint          cycles = 0;

  boundary_tag_pool_allocator_unit #(.POOL_BYTES(POOL_BYTES)) dut (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_req_bytes, .in_block_addr,
    .out_valid, .out_result_addr, .out_status, .out_used_bytes
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_result_addr, out_status, out_used_bytes);
  end

  function void track(logic [2:0] op, logic [15:0] ba, alloc_result_t r);
    if (r.status inside {ST_BADPTR, ST_DBLFREE, ST_CORRUPT} || op == OP_RESET) begin
      live.delete();
      return;
    end
    if ((op == OP_FREE || (op == OP_REALLOC && r.status == ST_OK)) && ba != 0)
      foreach (live[i]) if (live[i] == ba) begin
        live.delete(i);
        break;
      end
    if ((op == OP_ALLOC || op == OP_REALLOC) && r.status == ST_OK && r.addr != 0)
      live.push_back(r.addr);
  endfunction

  task automatic send(logic [2:0] op, logic [15:0] req, logic [15:0] ba);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk);
    end
    in_opcode = op;
    in_req_bytes = req;
    in_block_addr = ba;
    start = 1;
    do @(posedge clk); while (busy);
    track(op, ba, sb.note(op, req, ba));
    @(negedge clk);
  endtask

  function logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 0;
    if (r < 4) return 16'($urandom_range(0, 65535));
    if (r < 14) return 16'($urandom_range(65, 2000));
    return 16'($urandom_range(1, 64));
  endfunction

  function logic [15:0] pick_live();
    if (live.size() == 0) return 0;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  task automatic random_item();
    int r;
    logic [15:0] p;
    r = $urandom_range(0, 999);
    if (r < 400) send(OP_ALLOC, pick_size(), 16'($urandom_range(0, 65535)));
    else if (r < 690) begin
      p = pick_live();
      if ($urandom_range(0, 99) < 3)
        p = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                 : 16'(p + 4 * $urandom_range(1, 8));
      send(OP_FREE, 16'($urandom_range(0, 65535)), p);
    end else if (r < 850) begin
      p = $urandom_range(0, 9) == 0 ? 16'd0 : pick_live();
      send(OP_REALLOC, $urandom_range(0, 19) == 0 ? 16'd0 : pick_size(), p);
    end else if (r < 960) send(OP_USED, 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)));
    else if (r < 995) send(3'($urandom_range(5, 7)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
    else send(OP_RESET, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    logic [15:0] a;
    sb.clear_pool();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send(OP_ALLOC, 0, 0);
    send(OP_ALLOC, 16'hFFFF, 16'hFFFF);
    send(OP_ALLOC, 1, 0);
    send(OP_ALLOC, 12, 0);
    send(OP_ALLOC, 100, 0);
    send(OP_USED, 0, 0);
    send(OP_FREE, 0, 0);
    a = pick_live();
    send(OP_REALLOC, 4, a);
    send(OP_REALLOC, 40, a);
    send(OP_REALLOC, 500, pick_live());
    send(OP_REALLOC, 20, 0);
    send(OP_REALLOC, 0, pick_live());
    send(OP_FREE, 0, live[0]);
    send(OP_USED, 0, 0);
    send(OP_FREE, 0, 16'h0002);
    send(OP_ALLOC, 8, 0);
    a = live[0];
    send(OP_FREE, 0, a);
    send(OP_FREE, 0, a);
    send(OP_REALLOC, 8, 16'hFFFF);
    send(OP_FREE, 0, 16'd8);
    send(3'd5, 16'hFFFF, 16'hFFFF);
    send(3'd6, 0, 0);
    send(3'd7, 16'hAAAA, 16'h5555);
    send(OP_RESET, 0, 0);

    repeat (1400) random_item();
    start = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
